// ----- rtl/srioe_pkg.sv -----
// Shared types, character codes and the frame character table for the relay I/O expander.
package srioe_pkg;

  localparam int MAX_CH      = 9;
  localparam int PIN_W       = 6;
  localparam int RELAY_OUT_W = 8;
  localparam int QDEPTH      = 2;

  localparam logic [7:0] CH_0 = 8'h30;
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_D = 8'h44;
  localparam logic [7:0] CH_F = 8'h46;
  localparam logic [7:0] CH_G = 8'h47;
  localparam logic [7:0] CH_K = 8'h4B;

  // character positions within one report frame
  localparam logic [2:0] POS_HEAD0 = 3'd0;
  localparam logic [2:0] POS_HEAD1 = 3'd1;
  localparam logic [2:0] POS_ZERO0 = 3'd2;
  localparam logic [2:0] POS_CHAN  = 3'd3;
  localparam logic [2:0] POS_ZERO1 = 3'd4;
  localparam logic [2:0] POS_LEVEL = 3'd5;
  localparam logic [2:0] POS_TAILF = 3'd6;
  localparam logic [2:0] POS_TAILC = 3'd7;

  typedef struct packed {
    logic [MAX_CH-1:0]      mask;
    logic [MAX_CH-1:0]      levels;
    logic [RELAY_OUT_W-1:0] relays;
  } job_t;

  function automatic logic [7:0] frame_char(input logic [2:0] pos,
                                            input logic [7:0] chan,
                                            input logic       lvl);
    logic [7:0] c;
    case (pos)
      POS_HEAD0, POS_HEAD1, POS_TAILF: c = CH_F;
      POS_ZERO0, POS_ZERO1:            c = CH_0;
      POS_CHAN:                        c = chan;
      POS_LEVEL:                       c = CH_0 | {7'd0, lvl};
      POS_TAILC:                       c = CH_C;
      default:                         c = CH_0;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/srioe_front.sv -----
// Front end: command pairing, relay store and sample tracking; builds one report job per item.
module srioe_front import srioe_pkg::*; #(
  parameter int NUM_INPUTS = 6,
  parameter int NUM_RELAYS = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             take,
  input  logic             in_mode,
  input  logic [7:0]       in_rx_byte,
  input  logic [PIN_W-1:0] in_pin_levels,
  output job_t             job
);

  logic                  second_r, second_nxt;
  logic [7:0]            held_r, held_nxt;
  logic [NUM_RELAYS-1:0] relay_r, relay_nxt;
  logic                  seen_r, seen_nxt;
  logic [NUM_INPUTS-1:0] prev_r, prev_nxt;
  logic [NUM_INPUTS-1:0] rep_r, rep_nxt;

  logic [NUM_RELAYS-1:0] sel;
  logic [MAX_CH-1:0]     pins_ext;
  logic [NUM_INPUTS-1:0] pins;
  logic [NUM_INPUTS-1:0] mask;
  logic [NUM_INPUTS-1:0] levels;
  logic [MAX_CH-1:0]     relay_ext;

  assign pins_ext = {{(MAX_CH-PIN_W){1'b0}}, in_pin_levels};
  assign pins     = pins_ext[NUM_INPUTS-1:0];

  // one-hot relay select from the digit '1'..'0'+NUM_RELAYS
  always_comb begin
    for (int i = 0; i < NUM_RELAYS; i++) begin
      sel[i] = (in_rx_byte == 8'(int'(CH_0) + 1 + i));
    end
  end

  always_comb begin
    second_nxt = second_r;
    held_nxt   = held_r;
    relay_nxt  = relay_r;
    seen_nxt   = seen_r;
    prev_nxt   = prev_r;
    rep_nxt    = rep_r;
    mask       = '0;
    levels     = '0;
    if (!in_mode) begin
      if (!second_r) begin
        held_nxt   = in_rx_byte;
        second_nxt = 1'b1;
      end else begin
        second_nxt = 1'b0;
        if ((held_r == CH_K || held_r == CH_G) && (|sel)) begin
          if (held_r == CH_K) begin
            relay_nxt = relay_r & ~sel;
          end else begin
            relay_nxt = relay_r | sel;
          end
        end else if (held_r == CH_C && in_rx_byte == CH_D) begin
          mask   = '1;
          levels = prev_r;
        end
      end
    end else begin
      if (!seen_r) begin
        seen_nxt = 1'b1;
      end else if (pins != prev_r) begin
        // every input that differs from its reported level gets a frame
        mask    = pins ^ rep_r;
        levels  = pins;
        rep_nxt = pins;
      end
      prev_nxt = pins;
    end
  end

  assign relay_ext  = MAX_CH'(relay_nxt);
  assign job.mask   = MAX_CH'(mask);
  assign job.levels = MAX_CH'(levels);
  assign job.relays = relay_ext[RELAY_OUT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      second_r <= 1'b0;
      held_r   <= '0;
      relay_r  <= '1;
      seen_r   <= 1'b0;
      prev_r   <= '0;
      rep_r    <= '1;
    end else if (take) begin
      second_r <= second_nxt;
      held_r   <= held_nxt;
      relay_r  <= relay_nxt;
      seen_r   <= seen_nxt;
      prev_r   <= prev_nxt;
      rep_r    <= rep_nxt;
    end
  end

endmodule

// ----- rtl/srioe_fifo.sv -----
// Short job queue between the front and back ends.
module srioe_fifo import srioe_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output job_t pop_job
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  job_t             q_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign full      = (cnt_r == CNT_W'(QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_job   = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/srioe_back.sv -----
// Back end: walks a job's channel mask and streams report frames into the output register.
module srioe_back import srioe_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   job_valid,
  input  job_t                   job,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_tx_valid,
  output logic [7:0]             out_tx_byte,
  output logic                   out_tx_last,
  output logic [RELAY_OUT_W-1:0] out_relay_levels
);

  localparam int IDX_W = $clog2(MAX_CH);

  logic                   busy_r;
  logic [MAX_CH-1:0]      rem_r;
  logic [MAX_CH-1:0]      lvl_r;
  logic [RELAY_OUT_W-1:0] relays_r;
  logic [2:0]             pos_r;

  logic                   out_valid_r;
  logic                   out_tx_valid_r;
  logic [7:0]             out_tx_byte_r;
  logic                   out_tx_last_r;
  logic [RELAY_OUT_W-1:0] out_relay_r;

  logic [MAX_CH-1:0] low;
  logic [MAX_CH-1:0] rest;
  logic [IDX_W-1:0]  cidx;
  logic [7:0]        chan;
  logic              lvl;
  logic              has_frame;
  logic              advance;
  logic              is_last;

  assign low       = rem_r & (~rem_r + 1'b1);
  assign rest      = rem_r & ~low;
  assign has_frame = |rem_r;
  assign lvl       = |(low & lvl_r);

  always_comb begin
    cidx = '0;
    for (int i = MAX_CH - 1; i >= 0; i--) begin
      if (rem_r[i]) begin
        cidx = IDX_W'(i);
      end
    end
  end

  assign chan    = CH_0 + 8'(cidx) + 8'd1;
  assign advance = busy_r && (!out_valid_r || !out_stall);
  // a job with no frames gives a single empty beat
  assign is_last = !has_frame || (pos_r == POS_TAILC && rest == '0);
  assign pop     = job_valid && (!busy_r || (advance && is_last));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (pop) begin
        busy_r <= 1'b1;
      end else if (advance && is_last) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_tx_valid_r <= has_frame;
      out_tx_byte_r  <= has_frame ? frame_char(pos_r, chan, lvl) : 8'd0;
      out_tx_last_r  <= is_last;
      out_relay_r    <= relays_r;
      pos_r          <= pos_r + 3'd1;
      if (pos_r == POS_TAILC) begin
        rem_r <= rest;
      end
    end
    if (pop) begin
      rem_r    <= job.mask;
      lvl_r    <= job.levels;
      relays_r <= job.relays;
      pos_r    <= POS_HEAD0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_tx_valid     = out_tx_valid_r;
  assign out_tx_byte      = out_tx_byte_r;
  assign out_tx_last      = out_tx_last_r;
  assign out_relay_levels = out_relay_r;

endmodule

// ----- rtl/serial_relay_io_expander.sv -----
// Top level of the serially commanded relay I/O expander.
// Serial bytes pair into command and argument ('K'/'G' with a digit clear/set a relay,
// 'C' 'D' dumps all inputs); pin samples report changed inputs as 8-character frames
// F F 0 <channel> 0 <level> F C. An item is taken whenever the two-entry job
// queue has room, so the front end runs ahead of the output. The back end sends one
// character per output beat: an item costs one 8-character frame per reported input (up
// to NUM_INPUTS frames) or its single empty beat, and that character count sets the
// sustained throughput. Every item ends with a beat marked out_tx_last; out_relay_levels
// carries the relay state after the item on every beat it produces.
module serial_relay_io_expander import srioe_pkg::*; #(
  parameter int NUM_INPUTS = 6,
  parameter int NUM_RELAYS = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_mode,
  input  logic [7:0]             in_rx_byte,
  input  logic [PIN_W-1:0]       in_pin_levels,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_tx_valid,
  output logic [7:0]             out_tx_byte,
  output logic                   out_tx_last,
  output logic [RELAY_OUT_W-1:0] out_relay_levels
);

  logic take;
  logic q_full;
  logic q_not_empty;
  logic q_pop;
  job_t front_job;
  job_t q_job;

  assign in_stall = q_full;
  assign take     = in_valid && !in_stall;

  srioe_front #(
    .NUM_INPUTS (NUM_INPUTS),
    .NUM_RELAYS (NUM_RELAYS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .take          (take),
    .in_mode       (in_mode),
    .in_rx_byte    (in_rx_byte),
    .in_pin_levels (in_pin_levels),
    .job           (front_job)
  );

  srioe_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (take),
    .push_job  (front_job),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_job   (q_job)
  );

  srioe_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .job_valid        (q_not_empty),
    .job              (q_job),
    .pop              (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_tx_valid     (out_tx_valid),
    .out_tx_byte      (out_tx_byte),
    .out_tx_last      (out_tx_last),
    .out_relay_levels (out_relay_levels)
  );

  // an empty beat is always the only beat of its item, and carries a zero byte
  a_empty_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_tx_valid |-> out_tx_last && out_tx_byte == 8'd0)
    else $error("empty beat not last or byte not zero");

  // the last character of an item with frames closes a frame
  a_last_closes_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tx_valid && out_tx_last |-> out_tx_byte == CH_C)
    else $error("item ended mid-frame");

  // relay levels stay put across the beats of one item
  a_relays_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_tx_last |=> $stable(out_relay_levels))
    else $error("relay levels changed within an item");

endmodule

// ----- dv/tb_serial_relay_io_expander.sv -----
// Testbench for the serial relay I/O expander: directed table, random traffic, beat checker.
`timescale 1ns / 100ps

module tb_serial_relay_io_expander import srioe_pkg::*; ();

  localparam int N_DIRECTED = 26;
  localparam int N_ITEMS    = 130;
  localparam int IDLE_LIMIT = 5000;
  localparam int HOLD_BEATS = 240;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       tx_last;
    logic [7:0] relays;
  } char_beat_t;

  // quoted rows carry a typed-in single empty beat with the relay levels shown
  typedef struct packed {
    logic       mode;
    logic [7:0] rx;
    logic [5:0] pins;
    logic       quoted;
    logic [7:0] relays;
  } stim_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic                   in_mode;
  logic [7:0]             in_rx_byte;
  logic [PIN_W-1:0]       in_pin_levels;
  logic                   out_valid;
  logic                   out_stall;
  logic                   out_tx_valid;
  logic [7:0]             out_tx_byte;
  logic                   out_tx_last;
  logic [RELAY_OUT_W-1:0] out_relay_levels;

  serial_relay_io_expander dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_rx_byte       (in_rx_byte),
    .in_pin_levels    (in_pin_levels),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_tx_valid     (out_tx_valid),
    .out_tx_byte      (out_tx_byte),
    .out_tx_last      (out_tx_last),
    .out_relay_levels (out_relay_levels)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // board state as seen from outside
  logic       pair_half;
  logic [7:0] cmd_byte;
  logic [7:0] relay_now;
  logic       sample_primed;
  logic [5:0] last_sample;
  logic [5:0] reported;

  char_beat_t pending_chars [$];
  logic [7:0] frame_chars [$];

  int mismatches   = 0;
  int items_sent   = 0;
  int run_phase    = 0;
  int src_gap_pct  = 0;
  int sink_stall_pct = 0;
  int hold_left    = 0;
  bit hold_done    = 1'b0;
  int quiet_cycles = 0;

  stim_row_t directed_rows [0:N_DIRECTED-1] = '{
    {1'b0, CH_K,          6'h3F, 1'b1, 8'hFF},
    {1'b0, CH_0 + 8'd1,   6'h00, 1'b1, 8'hFE},
    {1'b0, CH_K,          6'h2A, 1'b1, 8'hFE},
    {1'b0, CH_0 + 8'd8,   6'h15, 1'b1, 8'h7E},
    {1'b0, CH_G,          6'h00, 1'b1, 8'h7E},
    {1'b0, CH_0 + 8'd9,   6'h00, 1'b1, 8'h7E},   // digit past the last relay
    {1'b0, CH_K,          6'h00, 1'b1, 8'h7E},
    {1'b0, CH_0,          6'h00, 1'b1, 8'h7E},   // digit below the first relay
    {1'b0, CH_C,          6'h00, 1'b1, 8'h7E},
    {1'b0, CH_D,          6'h00, 1'b0, 8'h00},   // dump before any sample
    {1'b0, CH_C,          6'h00, 1'b1, 8'h7E},
    {1'b0, CH_D + 8'd1,   6'h00, 1'b1, 8'h7E},   // unknown pair
    {1'b0, 8'hFF,         6'h3F, 1'b1, 8'h7E},
    {1'b0, 8'h00,         6'h00, 1'b1, 8'h7E},
    {1'b1, 8'hFF,         6'h00, 1'b1, 8'h7E},   // first sample only primes
    {1'b1, 8'h00,         6'h00, 1'b1, 8'h7E},   // unchanged sample
    {1'b1, 8'h00,         6'h3F, 1'b1, 8'h7E},   // changed, but matches reported
    {1'b1, 8'h00,         6'h00, 1'b0, 8'h00},
    {1'b1, 8'h5A,         6'h15, 1'b0, 8'h00},
    {1'b0, CH_C,          6'h00, 1'b1, 8'h7E},
    {1'b0, CH_D,          6'h00, 1'b0, 8'h00},
    {1'b0, CH_G,          6'h00, 1'b1, 8'h7E},
    {1'b1, 8'h00,         6'h2A, 1'b0, 8'h00},   // sample between command and argument
    {1'b0, CH_0 + 8'd8,   6'h00, 1'b1, 8'hFE},
    {1'b0, CH_G,          6'h00, 1'b1, 8'hFE},
    {1'b0, CH_0 + 8'd1,   6'h00, 1'b1, 8'hFF}
  };

  task automatic add_frame(input int chan, input logic lvl);
    begin
      frame_chars.push_back(CH_F);
      frame_chars.push_back(CH_F);
      frame_chars.push_back(CH_0);
      frame_chars.push_back(CH_0 + chan[7:0]);
      frame_chars.push_back(CH_0);
      frame_chars.push_back(CH_0 | {7'd0, lvl});
      frame_chars.push_back(CH_F);
      frame_chars.push_back(CH_C);
    end
  endtask

  task automatic relay_board_step(input logic m, input logic [7:0] rx, input logic [5:0] pins,
                                  input logic quoted, input logic [7:0] quoted_relays);
    logic [7:0] bit_sel;
    char_beat_t beat;
    begin
      frame_chars.delete();
      if (!m) begin
        if (!pair_half) begin
          cmd_byte  = rx;
          pair_half = 1'b1;
        end else begin
          pair_half = 1'b0;
          if ((cmd_byte == CH_K || cmd_byte == CH_G) &&
              rx >= CH_0 + 8'd1 && rx <= CH_0 + 8'd8) begin
            bit_sel   = 8'd1 << (rx - CH_0 - 8'd1);
            relay_now = (cmd_byte == CH_K) ? (relay_now & ~bit_sel) : (relay_now | bit_sel);
          end else if (cmd_byte == CH_C && rx == CH_D) begin
            for (int i = 0; i < 6; i++) add_frame(i + 1, last_sample[i]);
          end
        end
      end else begin
        if (!sample_primed) begin
          sample_primed = 1'b1;
        end else if (pins != last_sample) begin
          for (int i = 0; i < 6; i++) begin
            if (pins[i] != reported[i]) begin
              add_frame(i + 1, pins[i]);
              reported[i] = pins[i];
            end
          end
        end
        last_sample = pins;
      end

      if (quoted) begin
        beat = {1'b0, 8'h00, 1'b1, quoted_relays};
        pending_chars.push_back(beat);
      end else if (frame_chars.size() == 0) begin
        beat = {1'b0, 8'h00, 1'b1, relay_now};
        pending_chars.push_back(beat);
      end else begin
        for (int k = 0; k < frame_chars.size(); k++) begin
          beat = {1'b1, frame_chars[k], k == frame_chars.size() - 1, relay_now};
          pending_chars.push_back(beat);
        end
      end
    end
  endtask

  // entered and left at a falling edge
  task automatic offer_item(input logic m, input logic [7:0] rx, input logic [5:0] pins,
                            input logic quoted, input logic [7:0] quoted_relays);
    begin
      while ($urandom_range(99) < src_gap_pct) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
      in_valid      <= 1'b1;
      in_mode       <= m;
      in_rx_byte    <= rx;
      in_pin_levels <= pins;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      relay_board_step(m, rx, pins, quoted, quoted_relays);
      items_sent++;
      @(negedge clk);
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    begin
      if (want !== got) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
    end
  endtask

  always @(posedge clk) begin
    char_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_chars.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected beat, expected none, actual tx_valid %b byte %h last %b relays %h",
                 $time, out_tx_valid, out_tx_byte, out_tx_last, out_relay_levels);
      end else begin
        want = pending_chars.pop_front();
        check_field("tx_valid", {7'd0, want.tx_valid}, {7'd0, out_tx_valid});
        check_field("tx_byte", want.tx_byte, out_tx_byte);
        check_field("tx_last", {7'd0, want.tx_last}, {7'd0, out_tx_last});
        check_field("relay_levels", want.relays, out_relay_levels);
      end
    end
  end

  // sink side; one long hold-off when the back-to-back phase begins so the job queue fills
  always @(negedge clk) begin
    if (run_phase == 2 && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_BEATS;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("FAIL serial_relay_io_expander");
      $finish;
    end
  end

  initial begin
    logic [7:0] cmd;
    logic [7:0] arg;
    logic [5:0] pins;
    int         pick;

    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_mode        = 1'b0;
    in_rx_byte     = 8'h00;
    in_pin_levels  = '0;
    pair_half      = 1'b0;
    cmd_byte       = 8'h00;
    relay_now      = 8'hFF;
    sample_primed  = 1'b0;
    last_sample    = 6'h00;
    reported       = 6'h3F;
    src_gap_pct    = 23;
    sink_stall_pct = 55;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int r = 0; r < N_DIRECTED; r++)
      offer_item(directed_rows[r].mode, directed_rows[r].rx, directed_rows[r].pins,
                 directed_rows[r].quoted, directed_rows[r].relays);

    while (items_sent < N_ITEMS) begin
      if (items_sent >= 95) begin
        run_phase = 2; src_gap_pct = 0; sink_stall_pct = 0;
      end else if (items_sent >= 60) begin
        run_phase = 1; src_gap_pct = 55; sink_stall_pct = 23;
      end
      pick = $urandom_range(99);
      if (pick < 45) begin
        // command pair, mostly well-formed, now and then split by a pin sample
        case ($urandom_range(9))
          0, 1, 2, 3: cmd = CH_K;
          4, 5, 6, 7: cmd = CH_G;
          default:    cmd = CH_C;
        endcase
        if (cmd == CH_C) arg = ($urandom_range(4) != 0) ? CH_D : 8'($urandom);
        else if ($urandom_range(9) != 0) arg = CH_0 + 8'($urandom_range(1, 8));
        else arg = $urandom_range(1) ? CH_0 : CH_0 + 8'd9;
        offer_item(1'b0, cmd, 6'($urandom), 1'b0, 8'h00);
        if ($urandom_range(9) == 0) offer_item(1'b1, 8'($urandom), 6'($urandom), 1'b0, 8'h00);
        offer_item(1'b0, arg, 6'($urandom), 1'b0, 8'h00);
      end else if (pick < 80) begin
        case ($urandom_range(2))
          0:       pins = 6'($urandom);
          1:       pins = last_sample ^ (6'd1 << $urandom_range(5));
          default: pins = last_sample;
        endcase
        offer_item(1'b1, 8'($urandom), pins, 1'b0, 8'h00);
      end else begin
        offer_item(1'b0, 8'($urandom), 6'($urandom), 1'b0, 8'h00);
      end
    end
    in_valid <= 1'b0;

    while (pending_chars.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    if (mismatches == 0) begin
      $display("PASS serial_relay_io_expander");
    end else begin
      $display("FAIL serial_relay_io_expander");
    end
    $finish;
  end

endmodule
